FILE: rtl/cvg_pkg.sv
`default_nettype none
package cvg_pkg;

	localparam int MAX_LEN = 8;
	localparam int LEN_W = 4;
	localparam int CAND_W = 64;
	localparam int COUNT_W = 27;
	localparam int DIGIT_W = 4;

	localparam logic [7:0] DIGIT_BELOW = 8'd47;
	localparam logic [7:0] DIGIT_ABOVE = 8'd58;
	localparam logic [7:0] LOWER_BELOW = 8'd96;
	localparam logic [7:0] LOWER_ABOVE = 8'd123;
	localparam logic [7:0] UPPER_BELOW = 8'd64;
	localparam logic [7:0] UPPER_ABOVE = 8'd91;
	localparam logic [7:0] CASE_GAP = 8'd32;
	localparam logic [7:0] DIGIT_ZERO = 8'd48;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_NEXT   = 2'd2
	} op_t;

	localparam logic [1:0] CFG_EXCL_DIGITS = 2'd0;
	localparam logic [1:0] CFG_EXCL_LETTERS = 2'd1;

	// shared controls for the whole row of cells
	typedef struct packed {
		logic clear_odo;
		logic step;
		logic excl_digits;
		logic excl_letters;
	} cell_ctrl_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c > DIGIT_BELOW) && (c < DIGIT_ABOVE);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c > LOWER_BELOW) && (c < LOWER_ABOVE);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c > UPPER_BELOW) && (c < UPPER_ABOVE);
	endfunction

	function automatic logic [DIGIT_W-1:0] opt_count(input logic [7:0] c, input logic xd,
			input logic xl);
		logic [DIGIT_W-1:0] n;
		n = 4'd1;
		if (is_digit(c)) begin
			n = xd ? 4'd1 : 4'd10;
		end else if (is_lower(c) || is_upper(c)) begin
			n = xl ? 4'd1 : 4'd2;
		end
		return n;
	endfunction

	function automatic logic [7:0] opt_byte(input logic [7:0] c, input logic [DIGIT_W-1:0] idx,
			input logic xd, input logic xl);
		logic [7:0] b;
		b = c;
		if (is_digit(c)) begin
			if (!xd) begin
				b = DIGIT_ZERO + {4'd0, idx};
			end
		end else if (!xl) begin
			if (is_lower(c)) begin
				b = (idx != '0) ? c - CASE_GAP : c;
			end else if (is_upper(c)) begin
				b = (idx != '0) ? c : c + CASE_GAP;
			end
		end
		return b;
	endfunction

	function automatic logic [COUNT_W-1:0] pow10(input logic [LEN_W-1:0] e);
		logic [COUNT_W-1:0] p;
		case (e)
			4'd0: p = 27'd1;
			4'd1: p = 27'd10;
			4'd2: p = 27'd100;
			4'd3: p = 27'd1000;
			4'd4: p = 27'd10000;
			4'd5: p = 27'd100000;
			4'd6: p = 27'd1000000;
			4'd7: p = 27'd10000000;
			4'd8: p = 27'd100000000;
			default: p = 27'd1;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/cvg_cell.sv
`default_nettype none
module cvg_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cvg_pkg::cell_ctrl_t          ctrl,
	input  wire logic                         active,
	input  wire logic                         active_next,
	input  wire logic                         load,
	input  wire logic [7:0]                   char_in,
	input  wire logic                         carry_in,
	output logic                              carry_out,
	output logic [7:0]                        opt_out,
	output logic                              at_last,
	output logic                              digit_opt,
	output logic                              letter_opt
);
	import cvg_pkg::*;

	logic [7:0]         byte_q;
	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] digit_d;
	logic [DIGIT_W-1:0] n;
	logic [DIGIT_W-1:0] idx;
	logic [7:0]         nb;

	always_comb begin
		n = opt_count(byte_q, ctrl.excl_digits, ctrl.excl_letters);
		idx = (digit_q >= n) ? '0 : digit_q;
		opt_out = opt_byte(byte_q, idx, ctrl.excl_digits, ctrl.excl_letters);
		at_last = (digit_q == n - 4'd1);
		digit_d = digit_q;
		carry_out = carry_in;
		if (active) begin
			carry_out = 1'b0;
			if (carry_in) begin
				// wrap also when a stale digit sits at or above the count
				if ({1'b0, digit_q} + 5'd1 < {1'b0, n}) begin
					digit_d = digit_q + 4'd1;
				end else begin
					digit_d = '0;
					carry_out = 1'b1;
				end
			end
		end
		nb = load ? char_in : byte_q;
		digit_opt = active_next && is_digit(nb) && !ctrl.excl_digits;
		letter_opt = active_next && (is_lower(nb) || is_upper(nb)) && !ctrl.excl_letters;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear_odo) begin
			digit_q <= '0;
		end else if (ctrl.step) begin
			digit_q <= digit_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/case_digit_variant_generator.sv
// The result of an accepted input beat is captured in the output register.
// One beat per cycle is taken while the held result is taken or absent; the odometer
// carry ripples combinationally through all cells.
// Reset (arst_n low, asynchronous): empty word, odometer at the first variant,
// both exclude bits clear, no result pending.
`default_nettype none
module case_digit_variant_generator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      opcode,
	input  wire logic [7:0]                      char_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [cvg_pkg::CAND_W-1:0]           candidate,
	output logic [cvg_pkg::LEN_W-1:0]            word_length,
	output logic [cvg_pkg::COUNT_W-1:0]          total_count,
	output logic                                 is_last,
	output logic                                 overflow,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic                            cfg_data
);
	import cvg_pkg::*;

	logic               excl_digits_q;
	logic               excl_letters_q;
	logic [LEN_W-1:0]   length_q;
	logic [LEN_W-1:0]   length_d;
	logic               out_valid_q;
	logic [CAND_W-1:0]  candidate_q;
	logic [LEN_W-1:0]   word_length_q;
	logic [COUNT_W-1:0] total_count_q;
	logic               is_last_q;
	logic               overflow_q;

	logic               acc;
	logic               full;
	logic               do_append;
	logic               do_next;
	logic               ovf_d;
	logic               last_d;
	logic [CAND_W-1:0]  cand_d;
	logic [COUNT_W-1:0] total_d;
	logic [LEN_W-1:0]   n_digits;
	logic [LEN_W-1:0]   n_letters;
	cell_ctrl_t         ctrl;

	logic [MAX_LEN:0]   carry;
	logic [7:0]         opt [MAX_LEN];
	logic [MAX_LEN-1:0] at_last;
	logic [MAX_LEN-1:0] dig_opt;
	logic [MAX_LEN-1:0] let_opt;
	logic [MAX_LEN-1:0] active;
	logic [MAX_LEN-1:0] active_next;
	logic [MAX_LEN-1:0] load;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign acc = in_valid && in_ready;
	assign full = (length_q >= LEN_W'(MAX_LEN));

	always_comb begin
		do_append = 1'b0;
		do_next = 1'b0;
		ovf_d = 1'b0;
		length_d = length_q;
		ctrl.clear_odo = 1'b0;
		case (op_t'(opcode))
			OP_CLEAR: begin
				length_d = '0;
				ctrl.clear_odo = acc;
			end
			OP_APPEND: begin
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					do_append = 1'b1;
					length_d = length_q + 4'd1;
					ctrl.clear_odo = acc;
				end
			end
			OP_NEXT: begin
				do_next = 1'b1;
			end
			default: begin
			end
		endcase
		ctrl.step = acc && do_next;
		ctrl.excl_digits = excl_digits_q;
		ctrl.excl_letters = excl_letters_q;
	end

	assign carry[MAX_LEN] = do_next;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
			assign active[gi] = (LEN_W'(gi) < length_q);
			assign active_next[gi] = (LEN_W'(gi) < length_d);
			assign load[gi] = acc && do_append && (LEN_W'(gi) == length_q);

			cvg_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.active     (active[gi]),
				.active_next(active_next[gi]),
				.load       (load[gi]),
				.char_in    (char_in),
				.carry_in   (carry[gi+1]),
				.carry_out  (carry[gi]),
				.opt_out    (opt[gi]),
				.at_last    (at_last[gi]),
				.digit_opt  (dig_opt[gi]),
				.letter_opt (let_opt[gi])
			);
		end
	endgenerate

	always_comb begin
		cand_d = '0;
		last_d = do_next;
		for (int i = 0; i < MAX_LEN; i++) begin
			if (do_next && active[i]) begin
				cand_d[i*8 +: 8] = opt[i];
				if (!at_last[i]) begin
					last_d = 1'b0;
				end
			end
		end
		n_digits = LEN_W'($countones(dig_opt));
		n_letters = LEN_W'($countones(let_opt));
		// every varying digit gives a factor of ten, every letter a factor of two
		total_d = pow10(n_digits) << n_letters;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excl_digits_q <= 1'b0;
			excl_letters_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EXCL_DIGITS: excl_digits_q <= cfg_data;
				CFG_EXCL_LETTERS: excl_letters_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				length_q <= length_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until the beat is taken
	always_ff @(posedge clk) begin
		if (acc) begin
			candidate_q <= cand_d;
			word_length_q <= length_d;
			total_count_q <= total_d;
			is_last_q <= last_d;
			overflow_q <= ovf_d;
		end
	end

	assign out_valid = out_valid_q;
	assign candidate = candidate_q;
	assign word_length = word_length_q;
	assign total_count = total_count_q;
	assign is_last = is_last_q;
	assign overflow = overflow_q;

endmodule
`default_nettype wire

FILE: sim/tb_case_digit_variant_generator.sv
`timescale 1ns / 100ps
module tb_case_digit_variant_generator;
	import cvg_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int ITEM_GOAL = 1450;
	localparam int N_PHASES = 8;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [CAND_W-1:0]  cand;
		logic [LEN_W-1:0]   len;
		logic [COUNT_W-1:0] total;
		logic               last;
		logic               ovf;
	} variant_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic       typed;
		variant_t   want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = OP_CLEAR;
	logic [7:0] char_in = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CAND_W-1:0] candidate;
	logic [LEN_W-1:0] word_length;
	logic [COUNT_W-1:0] total_count;
	logic is_last;
	logic overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_EXCL_DIGITS;
	logic cfg_data = 1'b0;

	// predictor state
	logic [7:0] word_q [MAX_LEN];
	logic [LEN_W-1:0] len_q = '0;
	logic [DIGIT_W-1:0] odo_q [MAX_LEN] = '{default: '0};
	logic excl_dig = 1'b0;
	logic excl_let = 1'b0;

	variant_t pending_q [$];
	int errors = 0;
	int items_sent = 0;
	int quiet = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	int gap_tab [N_PHASES] = '{0, 65, 0, 26, 0, 65, 0, 26};
	int stall_tab [N_PHASES] = '{0, 0, 65, 26, 0, 0, 65, 26};
	logic xd_tab [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
	logic xl_tab [N_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};

	case_digit_variant_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.candidate(candidate),
		.word_length(word_length),
		.total_count(total_count),
		.is_last(is_last),
		.overflow(overflow),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic is_num(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [DIGIT_W-1:0] span_of(input logic [7:0] c);
		if (is_num(c)) begin
			return excl_dig ? 4'd1 : 4'd10;
		end
		if (is_alpha(c)) begin
			return excl_let ? 4'd1 : 4'd2;
		end
		return 4'd1;
	endfunction

	// out-of-range odometer digits read as the first option
	function automatic logic [7:0] face_of(input logic [7:0] c, input logic [DIGIT_W-1:0] idx);
		logic [DIGIT_W-1:0] k;
		k = (idx >= span_of(c)) ? '0 : idx;
		if (is_num(c)) begin
			return excl_dig ? c : 8'h30 + {4'd0, k};
		end
		if (!excl_let && c >= 8'h61 && c <= 8'h7A) begin
			return (k != 0) ? c - 8'h20 : c;
		end
		if (!excl_let && c >= 8'h41 && c <= 8'h5A) begin
			return (k != 0) ? c : c + 8'h20;
		end
		return c;
	endfunction

	function automatic logic [COUNT_W-1:0] word_total();
		logic [COUNT_W-1:0] t;
		int i;
		t = 1;
		for (i = 0; i < len_q; i++) begin
			t = t * span_of(word_q[i]);
		end
		return t;
	endfunction

	function automatic variant_t step_word(input logic [1:0] op, input logic [7:0] ch);
		variant_t r;
		logic done;
		int i;
		r = '0;
		case (op)
			OP_CLEAR: begin
				len_q = '0;
				for (i = 0; i < MAX_LEN; i++) odo_q[i] = '0;
			end
			OP_APPEND: begin
				if (len_q < MAX_LEN) begin
					word_q[len_q[2:0]] = ch;
					len_q = len_q + 1'b1;
					for (i = 0; i < MAX_LEN; i++) odo_q[i] = '0;
				end else begin
					r.ovf = 1'b1;
				end
			end
			OP_NEXT: begin
				r.last = 1'b1;
				for (i = 0; i < len_q; i++) begin
					r.cand[8*i +: 8] = face_of(word_q[i], odo_q[i]);
					if (odo_q[i] != span_of(word_q[i]) - 1'b1) r.last = 1'b0;
				end
				// advance, last position fastest
				done = 1'b0;
				for (i = int'(len_q) - 1; i >= 0 && !done; i--) begin
					if (odo_q[i] + 1 < span_of(word_q[i])) begin
						odo_q[i] = odo_q[i] + 1'b1;
						done = 1'b1;
					end else begin
						odo_q[i] = '0;
					end
				end
			end
			default: ;
		endcase
		r.len = len_q;
		r.total = word_total();
		return r;
	endfunction

	function automatic logic [7:0] word_char();
		case ($urandom_range(9))
			0, 1, 2, 3: return 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
			4, 5: return 8'h30 + 8'($urandom_range(9));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic stim_row_t typed_row(input logic [1:0] op, input logic [7:0] ch,
			input logic [CAND_W-1:0] cand, input int len, input int total,
			input logic last, input logic ovf);
		stim_row_t s;
		s.op = op;
		s.ch = ch;
		s.typed = 1'b1;
		s.want.cand = cand;
		s.want.len = LEN_W'(len);
		s.want.total = COUNT_W'(total);
		s.want.last = last;
		s.want.ovf = ovf;
		return s;
	endfunction

	function automatic stim_row_t open_row(input logic [1:0] op, input logic [7:0] ch);
		stim_row_t s;
		s = '0;
		s.op = op;
		s.ch = ch;
		return s;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic typed,
			input variant_t want);
		variant_t calc;
		while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		char_in <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		calc = step_word(op, ch);
		pending_q.push_back(typed ? want : calc);
		items_sent++;
	endtask

	// hold the input side until every pending result has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_setting(input logic xd, input logic xl);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_EXCL_DIGITS;
		cfg_data <= xd;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		excl_dig = xd;
		cfg_index <= CFG_EXCL_LETTERS;
		cfg_data <= xl;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		excl_let = xl;
		cfg_valid <= 1'b0;
	endtask

	// mostly a fresh word walked through its variants, sometimes a stray beat
	task automatic random_burst();
		int k;
		int m;
		int pick;
		logic [COUNT_W-1:0] tot;
		variant_t none;
		none = '0;
		pick = $urandom_range(99);
		if (pick < 12) begin
			send_item(2'($urandom_range(OP_NOP)), 8'($urandom_range(255)), 1'b0, none);
		end else begin
			if (pick < 92) send_item(OP_CLEAR, 8'($urandom_range(255)), 1'b0, none);
			k = $urandom_range(MAX_LEN, 1);
			if ($urandom_range(9) == 0) k += $urandom_range(2, 1);
			repeat (k) send_item(OP_APPEND, word_char(), 1'b0, none);
			tot = word_total();
			m = (tot <= 64) ? int'(tot) + $urandom_range(3) : $urandom_range(40, 1);
			repeat (m) send_item(OP_NEXT, 8'($urandom_range(255)), 1'b0, none);
		end
	endtask

	task automatic cmp_field(input string tag, input logic [CAND_W-1:0] exp_v,
			input logic [CAND_W-1:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, tag, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : out_check
		variant_t head;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual candidate %h",
					$time, candidate);
			end else begin
				head = pending_q.pop_front();
				cmp_field("candidate", head.cand, candidate);
				cmp_field("word_length", CAND_W'(head.len), CAND_W'(word_length));
				cmp_field("total_count", CAND_W'(head.total), CAND_W'(total_count));
				cmp_field("is_last", CAND_W'(head.last), CAND_W'(is_last));
				cmp_field("overflow", CAND_W'(head.ovf), CAND_W'(overflow));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t dir_tab [$];
		int p;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_tab.push_back(typed_row(OP_NEXT, 8'h00, 64'h0, 0, 1, 1'b1, 1'b0));
		dir_tab.push_back(typed_row(OP_NOP, 8'hFF, 64'h0, 0, 1, 1'b0, 1'b0));
		dir_tab.push_back(typed_row(OP_APPEND, 8'h37, 64'h0, 1, 10, 1'b0, 1'b0));
		dir_tab.push_back(typed_row(OP_NEXT, 8'h00, 64'h30, 1, 10, 1'b0, 1'b0));
		dir_tab.push_back(open_row(OP_NEXT, 8'hFF));
		dir_tab.push_back(typed_row(OP_APPEND, 8'h61, 64'h0, 2, 20, 1'b0, 1'b0));
		dir_tab.push_back(typed_row(OP_NEXT, 8'h00, 64'h6130, 2, 20, 1'b0, 1'b0));
		dir_tab.push_back(open_row(OP_NEXT, 8'h00));
		dir_tab.push_back(typed_row(OP_CLEAR, 8'hFF, 64'h0, 0, 1, 1'b0, 1'b0));
		dir_tab.push_back(typed_row(OP_APPEND, 8'h71, 64'h0, 1, 2, 1'b0, 1'b0));
		dir_tab.push_back(typed_row(OP_NEXT, 8'h00, 64'h71, 1, 2, 1'b0, 1'b0));
		dir_tab.push_back(typed_row(OP_NEXT, 8'h00, 64'h51, 1, 2, 1'b1, 1'b0));
		dir_tab.push_back(typed_row(OP_NEXT, 8'h00, 64'h71, 1, 2, 1'b0, 1'b0));
		// bytes just outside the digit and letter ranges stay fixed; 5A is a letter and varies
		dir_tab.push_back(open_row(OP_APPEND, 8'h2F));
		dir_tab.push_back(open_row(OP_APPEND, 8'h3A));
		dir_tab.push_back(open_row(OP_APPEND, 8'h40));
		dir_tab.push_back(open_row(OP_APPEND, 8'h5B));
		dir_tab.push_back(open_row(OP_APPEND, 8'h60));
		dir_tab.push_back(open_row(OP_APPEND, 8'h7B));
		dir_tab.push_back(open_row(OP_APPEND, 8'h5A));
		dir_tab.push_back(typed_row(OP_APPEND, 8'h00, 64'h0, 8, 4, 1'b0, 1'b1));
		dir_tab.push_back(typed_row(OP_APPEND, 8'hFF, 64'h0, 8, 4, 1'b0, 1'b1));
		repeat (4) dir_tab.push_back(open_row(OP_NEXT, 8'h55));

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].want);
		end

		// the word and odometer carry over so each new setting lands mid-order
		for (p = 0; p < N_PHASES; p++) begin
			drain();
			write_setting(xd_tab[p], xl_tab[p]);
			send_gap_pct = gap_tab[p];
			recv_stall_pct = stall_tab[p];
			while (items_sent < ITEM_GOAL * (2 * p + 1) / (2 * N_PHASES)) random_burst();
			if (p == 2) drain();
			while (items_sent < ITEM_GOAL * (p + 1) / N_PHASES) random_burst();
		end

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: case_digit_variant_generator.f
rtl/cvg_pkg.sv
rtl/cvg_cell.sv
rtl/case_digit_variant_generator.sv
sim/tb_case_digit_variant_generator.sv
